@@ hdl/snlu_pkg.sv @@
// Shared types and constants for the stochastic NEC lattice update block.
// No dependencies.
package snlu_pkg;

    localparam int SIDE_DEFAULT = 32;
    localparam int THR_W        = 17;
    localparam int DRAW_W       = 16;
    localparam int CELL_IDX_W   = 10;
    localparam int UP_W         = 11;
    localparam int CFG_IDX_W    = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLIP_UP   = 1'b0,
        REG_FLIP_DOWN = 1'b1
    } cfg_reg_t;

endpackage

@@ hdl/stochastic_nec_lattice_update.sv @@
// Top level of the stochastic NEC lattice update: spin row memory, update
// pipeline, result register. Depends on snlu_pkg.
//
// One cell is updated per accepted draw, and a new draw is taken every clock
// cycle while results are being taken; each draw passes the update stage and
// result registers. Both lattice buffers live in one memory of row words
// (SIDE bits wide, two buffers of 2**COL_W rows) with two registered read ports,
// one for the north row and one for the current row, and one write port that
// stores a row once its last cell is done. The memory needs no clearing pass:
// during the first sweep after reset all reads are returned as +1 spins, and
// every later read hits a row written in the sweep before. The row written at
// the end of a sweep is forwarded to a read of the same row at the same edge.
module stochastic_nec_lattice_update
#(
    parameter int SIDE = snlu_pkg::SIDE_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [snlu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [snlu_pkg::THR_W-1:0]        cfg_data,
    input  logic                              rand_valid,
    output logic                              rand_ready,
    input  logic [snlu_pkg::DRAW_W-1:0]       rand_draw,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [snlu_pkg::CELL_IDX_W-1:0]   cell_index,
    output logic                              new_spin,
    output logic                              sweep_done,
    output logic [snlu_pkg::UP_W-1:0]         up_total
);
    import snlu_pkg::*;

    localparam int COL_W     = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int CELLS     = SIDE * SIDE;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int ADDR_W    = COL_W + 1;
    localparam int MEM_DEPTH = 2 * (1 << COL_W);

    // configuration
    logic [THR_W-1:0] flip_up_reg;
    logic [THR_W-1:0] flip_down_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_up_reg   <= '0;
            flip_down_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FLIP_UP:   flip_up_reg   <= cfg_data;
                REG_FLIP_DOWN: flip_down_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // sweep position
    logic [COL_W-1:0]  row_reg, col_reg;
    logic [COL_W-1:0]  row_next, col_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              buf_reg, buf_next;
    logic              first_sweep_reg, first_sweep_next;
    logic              last_cell;
    logic [COL_W-1:0]  north_row, east_col;

    // update stage
    logic              s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]  s1_row_reg, s1_col_reg, s1_east_reg;
    logic [CELL_W-1:0] s1_cell_reg;
    logic              s1_wbuf_reg, s1_last_reg;
    logic [DRAW_W-1:0] s1_draw_reg;
    logic [SIDE-1:0]   rd_north_reg, rd_cur_reg;
    logic              s1_adv;
    logic              rand_accept;

    // memory
    logic [SIDE-1:0]   mem [MEM_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] waddr, raddr_n, raddr_c;
    logic [SIDE-1:0]   wdata;
    logic [SIDE-1:0]   row_acc_reg, row_acc_next;

    // result
    logic                  res_valid_reg, res_valid_next;
    logic [CELL_IDX_W-1:0] cell_index_reg;
    logic                  new_spin_reg, sweep_done_reg;
    logic [UP_W-1:0]       up_total_reg;
    logic [UP_W-1:0]       up_reg, up_next, up_sum;

    logic north_bit, east_bit, center_bit, nec_spin, spin;

    assign s1_adv      = s1_valid_reg && (!res_valid_reg || res_ready);
    assign rand_ready  = !s1_valid_reg || s1_adv;
    assign rand_accept = rand_valid && rand_ready;

    assign last_cell = (row_reg == COL_W'(SIDE - 1)) && (col_reg == COL_W'(SIDE - 1));
    assign north_row = (row_reg == '0) ? COL_W'(SIDE - 1) : row_reg - 1'b1;
    assign east_col  = (col_reg == COL_W'(SIDE - 1)) ? '0 : col_reg + 1'b1;

    assign raddr_n = {buf_reg, north_row};
    assign raddr_c = {buf_reg, row_reg};

    always_comb
    begin
        row_next         = row_reg;
        col_next         = col_reg;
        cell_next        = cell_reg;
        buf_next         = buf_reg;
        first_sweep_next = first_sweep_reg;
        if (rand_accept)
        begin
            if (last_cell)
            begin
                row_next         = '0;
                col_next         = '0;
                cell_next        = '0;
                buf_next         = ~buf_reg;
                first_sweep_next = 1'b0;
            end
            else
            begin
                cell_next = cell_reg + 1'b1;
                if (col_reg == COL_W'(SIDE - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg         <= '0;
            col_reg         <= '0;
            cell_reg        <= '0;
            buf_reg         <= 1'b0;
            first_sweep_reg <= 1'b1;
        end
        else
        begin
            row_reg         <= row_next;
            col_reg         <= col_next;
            cell_reg        <= cell_next;
            buf_reg         <= buf_next;
            first_sweep_reg <= first_sweep_next;
        end
    end

    // spin decision
    assign north_bit  = rd_north_reg[s1_col_reg];
    assign east_bit   = rd_cur_reg[s1_east_reg];
    assign center_bit = rd_cur_reg[s1_col_reg];
    assign nec_spin   = (north_bit == east_bit) ? north_bit : center_bit;

    always_comb
    begin
        if (nec_spin)
            spin = !({1'b0, s1_draw_reg} < flip_up_reg);
        else
            spin = ({1'b0, s1_draw_reg} < flip_down_reg);
    end

    assign up_sum = up_reg + UP_W'(spin);

    // row assembly and write-back
    always_comb
    begin
        wdata             = row_acc_reg;
        wdata[s1_col_reg] = spin;
    end

    assign row_acc_next = s1_adv ? wdata : row_acc_reg;
    assign mem_we       = s1_adv && (s1_col_reg == COL_W'(SIDE - 1));
    assign waddr        = {s1_wbuf_reg, s1_row_reg};

    always_ff @(posedge clk)
    begin
        row_acc_reg <= row_acc_next;
        if (mem_we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (rand_accept)
        begin
            if (first_sweep_reg)
                rd_north_reg <= '1;
            else if (mem_we && (waddr == raddr_n))
                rd_north_reg <= wdata;
            else
                rd_north_reg <= mem[raddr_n];

            if (first_sweep_reg)
                rd_cur_reg <= '1;
            else if (mem_we && (waddr == raddr_c))
                rd_cur_reg <= wdata;
            else
                rd_cur_reg <= mem[raddr_c];

            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_east_reg <= east_col;
            s1_cell_reg <= cell_reg;
            s1_wbuf_reg <= ~buf_reg;
            s1_last_reg <= last_cell;
            s1_draw_reg <= rand_draw;
        end
    end

    // stage and result control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rand_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (s1_adv)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;

        up_next = up_reg;
        if (s1_adv)
            up_next = s1_last_reg ? '0 : up_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            up_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            up_reg        <= up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            cell_index_reg <= CELL_IDX_W'(s1_cell_reg);
            new_spin_reg   <= spin;
            sweep_done_reg <= s1_last_reg;
            up_total_reg   <= s1_last_reg ? up_sum : '0;
        end
    end

    assign res_valid  = res_valid_reg;
    assign cell_index = cell_index_reg;
    assign new_spin   = new_spin_reg;
    assign sweep_done = sweep_done_reg;
    assign up_total   = up_total_reg;

    // checks
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        rand_accept |=> s1_valid_reg)
        else $error("accepted beat did not reach update stage");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_cell_reg)))
        else $error("stalled update stage lost its beat");

    a_sweep_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && sweep_done) |-> (cell_index == CELL_IDX_W'(CELLS - 1)))
        else $error("sweep end on wrong cell");

    a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !sweep_done) |-> (up_total == '0))
        else $error("up total reported mid sweep");

    a_first_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_sweep_reg) |-> $past(rand_accept && last_cell))
        else $error("fill flag cleared outside a sweep boundary");

endmodule
